### hdl/v4cos_pkg.sv
// shared types and constants for the 4d cosine similarity block
package v4cos_pkg;

  localparam int unsigned COMPONENT_BITS = 16;
  localparam int unsigned NCOMP = 4;
  localparam int unsigned OUT_W = 16;
  localparam int unsigned ONE_Q14 = 16384;
  localparam int unsigned MAG_W = 15;

  typedef struct packed {
    logic signed [COMPONENT_BITS-1:0] a_x;
    logic signed [COMPONENT_BITS-1:0] a_y;
    logic signed [COMPONENT_BITS-1:0] a_z;
    logic signed [COMPONENT_BITS-1:0] a_w;
    logic signed [COMPONENT_BITS-1:0] b_x;
    logic signed [COMPONENT_BITS-1:0] b_y;
    logic signed [COMPONENT_BITS-1:0] b_z;
    logic signed [COMPONENT_BITS-1:0] b_w;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] cosine;
    logic               zero_length;
  } out_beat_t;

endpackage

### hdl/v4cos_lane.sv
// one component lane: squares of both components and their product
module v4cos_lane #(
  parameter int unsigned CW = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [CW-1:0]     a,
  input  logic signed [CW-1:0]     b,
  output logic [2*CW-1:0]          aa_r,
  output logic [2*CW-1:0]          bb_r,
  output logic signed [2*CW-1:0]   ab_r
);

  logic signed [2*CW-1:0] aa_s;
  logic signed [2*CW-1:0] bb_s;

  assign aa_s = a * a;
  assign bb_s = b * b;

  always_ff @(posedge clk) begin
    if (en) begin
      aa_r <= aa_s;
      bb_r <= bb_s;
      ab_r <= a * b;
    end
  end

endmodule

### hdl/v4cos_merge.sv
// sums lane results into |a|^2, |b|^2 and the dot product
module v4cos_merge #(
  parameter int unsigned CW = 16
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [3:0][2*CW-1:0]       aa,
  input  logic [3:0][2*CW-1:0]       bb,
  input  logic signed [3:0][2*CW-1:0] ab,
  output logic [2*CW+1:0]            sa_r,
  output logic [2*CW+1:0]            sb_r,
  output logic signed [2*CW+2:0]     d_r
);

  localparam int unsigned SW = 2 * CW + 2;
  localparam int unsigned DW = 2 * CW + 3;

  logic [SW-1:0]        sa_s;
  logic [SW-1:0]        sb_s;
  logic signed [DW-1:0] d_s;

  always_comb begin
    sa_s = '0;
    sb_s = '0;
    d_s  = '0;
    for (int i = 0; i < 4; i++) begin
      sa_s = sa_s + SW'(aa[i]);
      sb_s = sb_s + SW'(bb[i]);
      d_s  = d_s + DW'($signed(ab[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa_r <= sa_s;
      sb_r <= sb_s;
      d_r  <= d_s;
    end
  end

endmodule

### hdl/v4cos_root.sv
// pipelined bit-at-a-time search for the largest r with r*r*s <= t
module v4cos_root #(
  parameter int unsigned SW = 34,
  parameter int unsigned DW = 35
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [SW-1:0]       sa,
  input  logic [SW-1:0]       sb,
  input  logic signed [DW-1:0] d,
  output logic                out_vld,
  output logic signed [15:0]  cosine,
  output logic                zero_length
);

  // stage widths: product s and target t = 2^28 * d^2
  localparam int unsigned PW = 2 * SW;
  localparam int unsigned RW = v4cos_pkg::MAG_W + 1;
  localparam int unsigned NB = RW;            // bits searched, 2^14 needs 15, plus 1
  localparam int unsigned LW = PW + 2 * RW;
  localparam int unsigned NST = NB + 1;

  // stage 0: product registers
  logic [PW-1:0]        s0_r;
  logic [PW-1:0]        dd0_r;
  logic                 neg0_r, zl0_r;
  logic [DW-1:0]        dm_s;

  // |d| never exceeds 2^32, so it fits the sum width
  assign dm_s = d[DW-1] ? DW'(-d) : DW'(d);

  logic [NST-1:0]       vld_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r   <= PW'(sa) * PW'(sb);
      dd0_r  <= PW'(SW'(dm_s)) * PW'(SW'(dm_s));
      neg0_r <= d[DW-1];
      zl0_r  <= (sa == '0) || (sb == '0);
    end
  end

  // search stages, one result bit each from the top
  // p carries r*r*s and q carries r*s so no stage needs a multiplier
  logic [NB:0][PW-1:0] s_r;
  logic [NB:0][LW-1:0] t_r;
  logic [NB:0][LW-1:0] p_r;
  logic [NB:0][LW-1:0] q_r;
  logic [NB:0][RW-1:0] r_r;
  logic [NB:0]         neg_r, zl_r;

  assign s_r[0]   = s0_r;
  assign t_r[0]   = LW'(dd0_r) << 28;
  assign p_r[0]   = '0;
  assign q_r[0]   = '0;
  assign r_r[0]   = '0;
  assign neg_r[0] = neg0_r;
  assign zl_r[0]  = zl0_r;

  for (genvar k = 0; k < NB; k++) begin : g_bit
    localparam int unsigned B = NB - 1 - k;
    logic [RW-1:0] cand;
    logic [LW-1:0] lhs;
    logic          take;
    logic [RW-1:0] rq_r;
    logic [PW-1:0] sq_r;
    logic [LW-1:0] tq_r;
    logic [LW-1:0] pq_r;
    logic [LW-1:0] qq_r;
    logic          nq_r, zq_r;
    assign cand = r_r[k] | (RW'(1) << B);
    // (r + 2^B)^2 * s = r*r*s + r*s*2^(B+1) + s*2^(2B)
    assign lhs  = p_r[k] + (q_r[k] << (B + 1)) + (LW'(s_r[k]) << (2 * B));
    assign take = (lhs <= t_r[k]) && (cand <= RW'(v4cos_pkg::ONE_Q14));
    always_ff @(posedge clk) begin
      if (en) begin
        rq_r <= take ? cand : r_r[k];
        pq_r <= take ? lhs : p_r[k];
        qq_r <= take ? q_r[k] + (LW'(s_r[k]) << B) : q_r[k];
        sq_r <= s_r[k];
        tq_r <= t_r[k];
        nq_r <= neg_r[k];
        zq_r <= zl_r[k];
      end
    end
    assign r_r[k+1]   = rq_r;
    assign p_r[k+1]   = pq_r;
    assign q_r[k+1]   = qq_r;
    assign s_r[k+1]   = sq_r;
    assign t_r[k+1]   = tq_r;
    assign neg_r[k+1] = nq_r;
    assign zl_r[k+1]  = zq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_vld};
    end
  end

  assign out_vld     = vld_r[NST-1];
  assign zero_length = zl_r[NB];
  assign cosine      = zl_r[NB] ? 16'sd0
                     : (neg_r[NB] ? -$signed(16'(r_r[NB])) : $signed(16'(r_r[NB])));

endmodule

### hdl/vec4_cosine_similarity.sv
// 4d cosine similarity top level: lanes, merge, root search, output register
// Accepts one vector pair per clock while in_ready is high; each result beat passes
// through the lane multiply, sum, product stage, sixteen search stages and output
// register in that order, with the one-bit-per-stage magnitude search. The whole
// pipeline stalls only when the output register is full and not taken.
module vec4_cosine_similarity (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  v4cos_pkg::in_beat_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output v4cos_pkg::out_beat_t  out_data
);

  localparam int unsigned CW = v4cos_pkg::COMPONENT_BITS;
  localparam int unsigned SW = 2 * CW + 2;
  localparam int unsigned DW = 2 * CW + 3;

  logic en;
  logic pipe_vld;
  logic [1:0] lane_vld_r;

  logic signed [3:0][CW-1:0] av, bv;
  logic [3:0][2*CW-1:0]        aa, bb;
  logic signed [3:0][2*CW-1:0] ab;
  logic [SW-1:0]        sa;
  logic [SW-1:0]        sb;
  logic signed [DW-1:0] d;
  logic signed [15:0]   cos_s;
  logic                 zl_s;

  assign av = {CW'(in_data.a_w), CW'(in_data.a_z), CW'(in_data.a_y), CW'(in_data.a_x)};
  assign bv = {CW'(in_data.b_w), CW'(in_data.b_z), CW'(in_data.b_y), CW'(in_data.b_x)};

  // pipeline advances unless the output register holds a beat that is not taken
  logic out_vld_r;
  v4cos_pkg::out_beat_t out_r;
  assign en       = !out_vld_r || out_ready;
  assign in_ready = en;

  for (genvar i = 0; i < 4; i++) begin : g_lane
    v4cos_lane #(.CW(CW)) u_lane (
      .clk(clk), .en(en), .a(av[i]), .b(bv[i]),
      .aa_r(aa[i]), .bb_r(bb[i]), .ab_r(ab[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_vld_r <= '0;
    end else if (en) begin
      lane_vld_r <= {lane_vld_r[0], in_valid};
    end
  end

  v4cos_merge #(.CW(CW)) u_merge (
    .clk(clk), .en(en), .aa(aa), .bb(bb), .ab(ab),
    .sa_r(sa), .sb_r(sb), .d_r(d)
  );

  v4cos_root #(.SW(SW), .DW(DW)) u_root (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(lane_vld_r[1]),
    .sa(sa), .sb(sb), .d(d),
    .out_vld(pipe_vld), .cosine(cos_s), .zero_length(zl_s)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= pipe_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r.cosine      <= cos_s;
      out_r.zero_length <= zl_s;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped while stalled");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_length |-> out_data.cosine == 16'sd0)
    else $error("zero length with nonzero cosine");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.cosine <= 16'sd16384 && out_data.cosine >= -16'sd16384)
    else $error("cosine out of range");
`endif

endmodule
